@@ hw/rtl/lzsd_pkg.sv @@
package lzsd_pkg;

    localparam int WINDOW_BYTES = 4096;
    localparam int HIST_AW      = 12;
    localparam int HDR_SIZE_W   = 24;
    localparam int LEN_W        = 5;

    localparam logic [2:0]       TYPE_LZ77  = 3'd1;
    localparam logic [LEN_W-1:0] MIN_MATCH  = 5'd3;
    localparam logic [3:0]       FLAG_COUNT = 4'd8;

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_FLAG,
        PH_LITERAL,
        PH_TOKEN_HI,
        PH_TOKEN_LO,
        PH_COPY,
        PH_DONE,
        PH_BAD_TYPE,
        PH_BAD_DIST
    } phase_t;

    typedef enum logic [1:0] {
        ST_RUNNING  = 2'd0,
        ST_FINISHED = 2'd1,
        ST_BAD_TYPE = 2'd2,
        ST_BAD_DIST = 2'd3
    } status_t;

    typedef struct packed {
        phase_t     ph;
        logic [7:0] flags;
        logic [3:0] left;
    } elem_t;

    function automatic status_t phase_status(input phase_t ph);
        status_t st;
        unique case (ph)
            PH_DONE:     st = ST_FINISHED;
            PH_BAD_TYPE: st = ST_BAD_TYPE;
            PH_BAD_DIST: st = ST_BAD_DIST;
            default:     st = ST_RUNNING;
        endcase
        return st;
    endfunction

endpackage

@@ hw/rtl/lz77_stream_decompressor_unit.sv @@
// LZ77 (LZSS) stream decompressor with a 4 KiB history window.
// The slave channel takes one compressed byte per request in s_tdata; s_tuser
// set marks the first header byte of a new stream and restarts the decoder.
// The master channel returns decoded bytes: m_tdata carries the byte and the
// decoder status, m_tuser says whether a byte is present and m_tlast marks
// the last result caused by one input request. An input that decodes nothing
// yields a single result without a byte.
// Results are registered in the output register. A literal, header or control
// byte yields its result directly from the request. The low byte of a match
// token is followed by one result per copied byte (up to 18), because the copy
// runs through the single read port of the history memory at one byte a cycle
// while the receiver keeps up; copied bytes pass the memory read register first.
// While a match is copied s_tready stays low. When the receiver stalls, the
// copy and the input side wait; a new request is taken only once the output
// register is empty or is being read in the same cycle.
// After reset the decoder waits for header byte zero; the history memory is
// not cleared, since every read hits a byte written in the current stream.
module lz77_stream_decompressor_unit #(
    parameter int SIZE_BITS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] start_req
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [9:8] status, [15:10] zero
    output logic        m_tuser,   // [0] has_byte
    output logic        m_tlast    // last_of_run
);

    localparam int AW      = lzsd_pkg::HIST_AW;
    localparam int LW      = lzsd_pkg::LEN_W;
    localparam int CMP_W   = (SIZE_BITS > AW) ? SIZE_BITS : AW;
    localparam int HDR_W_T = lzsd_pkg::HDR_SIZE_W;

    lzsd_pkg::phase_t  phase_reg, phase_next;
    logic [1:0]           hidx_reg, hidx_next;
    logic [SIZE_BITS-1:0] exp_reg, exp_next;
    logic [SIZE_BITS-1:0] wr_reg, wr_next;
    logic [7:0]           flags_reg, flags_next;
    logic [3:0]           left_reg, left_next;
    logic [7:0]           th_reg, th_next;
    logic [AW-1:0]        hp_reg, hp_next;
    logic [AW-1:0]        src_reg, src_next;
    logic [LW-1:0]        cnt_reg, cnt_next;
    lzsd_pkg::status_t mstat_reg, mstat_next;
    logic                 dz_reg, dz_next;
    logic                 first_reg, first_next;
    logic [7:0]           lastb_reg, lastb_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [7:0]           obyte_reg, obyte_next;
    logic                 ohas_reg, ohas_next;
    lzsd_pkg::status_t ostat_reg, ostat_next;
    logic                 olast_reg, olast_next;

    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [7:0]           ram_wdata, ram_rdata;

    logic                 out_free;

    lzsd_ram #(
        .WIDTH (8),
        .DEPTH (lzsd_pkg::WINDOW_BYTES)
    ) u_hist (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    function automatic lzsd_pkg::elem_t next_elem(
        input logic [SIZE_BITS-1:0] wr,
        input logic [SIZE_BITS-1:0] expct,
        input logic [7:0]           fl,
        input logic [3:0]           lf
    );
        lzsd_pkg::elem_t e;
        e.flags = fl;
        e.left  = lf;
        if (wr >= expct) begin
            e.ph = lzsd_pkg::PH_DONE;
        end else if (lf == 4'd0) begin
            e.ph = lzsd_pkg::PH_FLAG;
        end else begin
            e.ph    = fl[7] ? lzsd_pkg::PH_TOKEN_HI : lzsd_pkg::PH_LITERAL;
            e.flags = {fl[6:0], 1'b0};
            e.left  = lf - 4'd1;
        end
        return e;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= lzsd_pkg::PH_HEADER;
            hidx_reg     <= '0;
            exp_reg      <= '0;
            wr_reg       <= '0;
            flags_reg    <= '0;
            left_reg     <= '0;
            hp_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            hidx_reg     <= hidx_next;
            exp_reg      <= exp_next;
            wr_reg       <= wr_next;
            flags_reg    <= flags_next;
            left_reg     <= left_next;
            hp_reg       <= hp_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        th_reg    <= th_next;
        src_reg   <= src_next;
        cnt_reg   <= cnt_next;
        mstat_reg <= mstat_next;
        dz_reg    <= dz_next;
        first_reg <= first_next;
        lastb_reg <= lastb_next;
        obyte_reg <= obyte_next;
        ohas_reg  <= ohas_next;
        ostat_reg <= ostat_next;
        olast_reg <= olast_next;
    end

    always_comb begin
        lzsd_pkg::phase_t     eph;
        lzsd_pkg::elem_t      ne;
        logic [1:0]           ehi;
        logic [SIZE_BITS-1:0] eexp, ewr, rem;
        logic [7:0]           efl;
        logic [3:0]           elf;
        logic [AW-1:0]        ehp, disp, rd_addr;
        logic [LW-1:0]        len;
        logic [HDR_W_T-1:0]   hdr;
        logic [7:0]           cbyte;
        logic                 done;

        phase_next    = phase_reg;
        hidx_next     = hidx_reg;
        exp_next      = exp_reg;
        wr_next       = wr_reg;
        flags_next    = flags_reg;
        left_next     = left_reg;
        th_next       = th_reg;
        hp_next       = hp_reg;
        src_next      = src_reg;
        cnt_next      = cnt_reg;
        mstat_next    = mstat_reg;
        dz_next       = dz_reg;
        first_next    = first_reg;
        lastb_next    = lastb_reg;
        obyte_next    = obyte_reg;
        ohas_next     = ohas_reg;
        ostat_next    = ostat_reg;
        olast_next    = olast_reg;

        out_free      = !m_tvalid_reg || m_tready;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        s_tready      = (phase_reg != lzsd_pkg::PH_COPY) && out_free;

        ram_we    = 1'b0;
        ram_waddr = hp_reg;
        ram_wdata = s_tdata;
        ram_re    = 1'b0;
        ram_raddr = src_reg;

        eph     = s_tuser ? lzsd_pkg::PH_HEADER : phase_reg;
        ehi     = s_tuser ? 2'd0 : hidx_reg;
        eexp    = s_tuser ? '0 : exp_reg;
        ewr     = s_tuser ? '0 : wr_reg;
        efl     = s_tuser ? 8'd0 : flags_reg;
        elf     = s_tuser ? 4'd0 : left_reg;
        ehp     = s_tuser ? '0 : hp_reg;
        disp    = {th_reg[3:0], s_tdata};
        rd_addr = ehp - disp - AW'(1);
        len     = LW'(th_reg[7:4]) + lzsd_pkg::MIN_MATCH;
        rem     = eexp - ewr;
        done    = rem <= SIZE_BITS'(len);
        hdr     = HDR_W_T'(eexp) | (HDR_W_T'(s_tdata) << {ehi - 2'd1, 3'b000});
        cbyte   = (dz_reg && !first_reg) ? lastb_reg : ram_rdata;
        ne      = next_elem(ewr, eexp, efl, elf);

        if (s_tvalid && s_tready) begin
            hidx_next  = ehi;
            exp_next   = eexp;
            wr_next    = ewr;
            flags_next = efl;
            left_next  = elf;
            hp_next    = ehp;
            phase_next = eph;

            m_tvalid_next = 1'b1;
            obyte_next    = 8'd0;
            ohas_next     = 1'b0;
            olast_next    = 1'b1;

            unique case (eph)
                lzsd_pkg::PH_HEADER: begin
                    if (ehi == 2'd0) begin
                        if (s_tdata[6:4] != lzsd_pkg::TYPE_LZ77) begin
                            phase_next = lzsd_pkg::PH_BAD_TYPE;
                        end else begin
                            hidx_next = 2'd1;
                        end
                    end else begin
                        exp_next  = hdr[SIZE_BITS-1:0];
                        hidx_next = ehi + 2'd1;
                        if (ehi == 2'd3) begin
                            ne         = next_elem(ewr, hdr[SIZE_BITS-1:0], efl, elf);
                            phase_next = ne.ph;
                            flags_next = ne.flags;
                            left_next  = ne.left;
                        end
                    end
                end
                lzsd_pkg::PH_FLAG: begin
                    ne         = next_elem(ewr, eexp, s_tdata, lzsd_pkg::FLAG_COUNT);
                    phase_next = ne.ph;
                    flags_next = ne.flags;
                    left_next  = ne.left;
                end
                lzsd_pkg::PH_LITERAL: begin
                    ram_we     = 1'b1;
                    ram_waddr  = ehp;
                    ram_wdata  = s_tdata;
                    hp_next    = ehp + AW'(1);
                    wr_next    = ewr + SIZE_BITS'(1);
                    obyte_next = s_tdata;
                    ohas_next  = 1'b1;
                    ne         = next_elem(ewr + SIZE_BITS'(1), eexp, efl, elf);
                    phase_next = ne.ph;
                    flags_next = ne.flags;
                    left_next  = ne.left;
                end
                lzsd_pkg::PH_TOKEN_HI: begin
                    th_next    = s_tdata;
                    phase_next = lzsd_pkg::PH_TOKEN_LO;
                end
                lzsd_pkg::PH_TOKEN_LO: begin
                    if (CMP_W'(disp) >= CMP_W'(ewr)) begin
                        phase_next = lzsd_pkg::PH_BAD_DIST;
                    end else begin
                        ram_re        = 1'b1;
                        ram_raddr     = rd_addr;
                        src_next      = rd_addr;
                        cnt_next      = done ? rem[LW-1:0] : len;
                        mstat_next    = done ? lzsd_pkg::ST_FINISHED
                                             : lzsd_pkg::ST_RUNNING;
                        dz_next       = (disp == '0);
                        first_next    = 1'b1;
                        phase_next    = lzsd_pkg::PH_COPY;
                        m_tvalid_next = m_tvalid_reg && !m_tready;
                    end
                end
                default: begin
                end
            endcase
            ostat_next = lzsd_pkg::phase_status(phase_next);
        end else if (phase_reg == lzsd_pkg::PH_COPY && out_free) begin
            ram_we        = 1'b1;
            ram_waddr     = hp_reg;
            ram_wdata     = cbyte;
            hp_next       = hp_reg + AW'(1);
            wr_next       = wr_reg + SIZE_BITS'(1);
            lastb_next    = cbyte;
            first_next    = 1'b0;
            cnt_next      = cnt_reg - LW'(1);
            m_tvalid_next = 1'b1;
            obyte_next    = cbyte;
            ohas_next     = 1'b1;
            ostat_next    = mstat_reg;
            olast_next    = (cnt_reg == LW'(1));
            if (cnt_reg == LW'(1)) begin
                ne         = next_elem(wr_reg + SIZE_BITS'(1), exp_reg, flags_reg, left_reg);
                phase_next = ne.ph;
                flags_next = ne.flags;
                left_next  = ne.left;
            end else begin
                ram_re    = 1'b1;
                ram_raddr = src_reg + AW'(1);
                src_next  = src_reg + AW'(1);
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b000000, ostat_reg, obyte_reg};
    assign m_tuser  = ohas_reg;
    assign m_tlast  = olast_reg;

endmodule

@@ hw/rtl/lzsd_ram.sv @@
module lzsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ bench/lz77_stream_decompressor_unit_tb.sv @@
module lz77_stream_decompressor_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_DEMO     = 24;
    localparam int RAND_REQS  = 200;
    localparam int QUIET_MAX  = 2000;
    localparam int MODE_SPAN  = 40;

    typedef struct packed {
        logic [7:0]        data;
        logic              has;
        lzsd_pkg::status_t st;
        logic              last;
    } dec_result_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        restart;
        logic        typed;
        dec_result_t want;
    } req_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    lz77_stream_decompressor_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Decoder state mirrored on the testbench side.
    lzsd_pkg::phase_t  dec_phase;
    logic [1:0]        hdr_idx;
    logic [23:0]       size_total;
    logic [23:0]       n_written;
    logic [7:0]        flags;
    logic [3:0]        flags_left;
    logic [7:0]        tok_hi;
    logic [7:0]        hist [lzsd_pkg::WINDOW_BYTES];
    logic [lzsd_pkg::HIST_AW-1:0] hist_wr;
    logic [7:0]        run_bytes [$];
    dec_result_t       step_out [$];

    dec_result_t decoded_q [$];
    req_t        stim_q [$];
    req_t        demo_tbl [N_DEMO];
    dec_result_t head;

    int gap_pct   [4] = '{0, 59, 0, 17};
    int stall_pct [4] = '{0, 0, 59, 17};
    int idle_mode = 0;
    int n_fail    = 0;
    int n_results = 0;
    int n_streams = 0;
    int quiet     = 0;

    function void restart_decoder();
        dec_phase  = lzsd_pkg::PH_HEADER;
        hdr_idx    = 2'd0;
        size_total = '0;
        n_written  = '0;
        flags      = '0;
        flags_left = '0;
        tok_hi     = '0;
        hist_wr    = '0;
    endfunction

    function void store_byte(input logic [7:0] v);
        hist[hist_wr] = v;
        hist_wr = hist_wr + 1'b1;
        n_written = n_written + 1'b1;
        run_bytes.push_back(v);
    endfunction

    function void pick_element();
        if (n_written >= size_total) begin
            dec_phase = lzsd_pkg::PH_DONE;
        end else if (flags_left == 0) begin
            dec_phase = lzsd_pkg::PH_FLAG;
        end else begin
            dec_phase = flags[7] ? lzsd_pkg::PH_TOKEN_HI : lzsd_pkg::PH_LITERAL;
            flags = flags << 1;
            flags_left = flags_left - 1'b1;
        end
    endfunction

    function void decode_byte(input logic [7:0] b, input logic restart);
        logic [11:0]       disp;
        logic [11:0]       src;
        int                len;
        lzsd_pkg::status_t st;
        run_bytes = {};
        step_out = {};
        if (restart)
            restart_decoder();
        case (dec_phase)
            lzsd_pkg::PH_HEADER: begin
                if (hdr_idx == 2'd0) begin
                    if (b[6:4] != lzsd_pkg::TYPE_LZ77)
                        dec_phase = lzsd_pkg::PH_BAD_TYPE;
                    else
                        hdr_idx = 2'd1;
                end else begin
                    size_total[8*(hdr_idx-1) +: 8] = b;
                    hdr_idx = hdr_idx + 2'd1;
                    if (hdr_idx == 2'd0)
                        pick_element();
                end
            end
            lzsd_pkg::PH_FLAG: begin
                flags = b;
                flags_left = lzsd_pkg::FLAG_COUNT;
                pick_element();
            end
            lzsd_pkg::PH_LITERAL: begin
                store_byte(b);
                pick_element();
            end
            lzsd_pkg::PH_TOKEN_HI: begin
                tok_hi = b;
                dec_phase = lzsd_pkg::PH_TOKEN_LO;
            end
            lzsd_pkg::PH_TOKEN_LO: begin
                disp = {tok_hi[3:0], b};
                len = int'(lzsd_pkg::MIN_MATCH) + int'(tok_hi[7:4]);
                if (disp >= n_written) begin
                    dec_phase = lzsd_pkg::PH_BAD_DIST;
                end else begin
                    while (len > 0 && n_written < size_total) begin
                        src = hist_wr - disp - 12'd1;
                        store_byte(hist[src]);
                        len--;
                    end
                    pick_element();
                end
            end
            default: ;
        endcase
        case (dec_phase)
            lzsd_pkg::PH_DONE:     st = lzsd_pkg::ST_FINISHED;
            lzsd_pkg::PH_BAD_TYPE: st = lzsd_pkg::ST_BAD_TYPE;
            lzsd_pkg::PH_BAD_DIST: st = lzsd_pkg::ST_BAD_DIST;
            default:               st = lzsd_pkg::ST_RUNNING;
        endcase
        if (run_bytes.size() == 0)
            step_out.push_back('{8'h00, 1'b0, st, 1'b1});
        else
            foreach (run_bytes[k])
                step_out.push_back('{run_bytes[k], 1'b1, st, k == run_bytes.size() - 1});
    endfunction

    function void add_req(input logic [7:0] d, input logic r);
        req_t q;
        q = '0;
        q.data = d;
        q.restart = r;
        stim_q.push_back(q);
    endfunction

    // Builds one well-formed stream with random content. A token may be made to reach
    // before the start, and no new flag group starts once max_req requests are queued.
    function void emit_stream(input logic [23:0] size, input int bad_pct, input bit long_run,
                              input int max_req);
        int unsigned wr;
        int unsigned reach;
        int unsigned len;
        int unsigned disp;
        int          start_at;
        int          k;
        bit          stop;
        logic [7:0]  h0;
        logic [7:0]  fl;
        logic [7:0]  body [$];
        start_at = stim_q.size();
        n_streams++;
        h0 = 8'($urandom);
        h0[6:4] = lzsd_pkg::TYPE_LZ77;
        add_req(h0, 1'b1);
        add_req(size[7:0], 1'b0);
        add_req(size[15:8], 1'b0);
        add_req(size[23:16], 1'b0);
        wr = 0;
        stop = 1'b0;
        while (!stop && wr < size && stim_q.size() - start_at < max_req) begin
            fl = 8'($urandom);
            body = {};
            for (k = 7; k >= 0 && !stop && wr < size; k--) begin
                if ($urandom_range(99) < bad_pct && wr < lzsd_pkg::WINDOW_BYTES) begin
                    disp = ($urandom_range(1) == 1) ? wr
                         : $urandom_range(lzsd_pkg::WINDOW_BYTES - 1, wr);
                    fl[k] = 1'b1;
                    body.push_back({4'($urandom), disp[11:8]});
                    body.push_back(disp[7:0]);
                    stop = 1'b1;
                end else if (wr > 0 && $urandom_range(99) < (long_run ? 92 : 40)) begin
                    reach = (wr < lzsd_pkg::WINDOW_BYTES) ? wr - 1
                          : lzsd_pkg::WINDOW_BYTES - 1;
                    case ($urandom_range(3))
                        0:       disp = reach;
                        1:       disp = 0;
                        default: disp = $urandom_range(reach, 0);
                    endcase
                    len = (long_run && $urandom_range(3) != 0) ? 15 : $urandom_range(15);
                    fl[k] = 1'b1;
                    body.push_back({len[3:0], disp[11:8]});
                    body.push_back(disp[7:0]);
                    wr += (len + lzsd_pkg::MIN_MATCH < size - wr) ? len + lzsd_pkg::MIN_MATCH
                                                                  : size - wr;
                end else begin
                    fl[k] = 1'b0;
                    body.push_back(8'($urandom));
                    wr++;
                end
            end
            add_req(fl, 1'b0);
            foreach (body[j])
                add_req(body[j], 1'b0);
        end
    endfunction

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
    end

    initial begin
        while (quiet < QUIET_MAX)
            @(posedge aclk);
        $display("watchdog: no request moved for %0d cycles", QUIET_MAX);
        $display("status: fail");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (decoded_q.size() == 0) begin
                $error("unexpected result: m_tdata %h m_tuser %b m_tlast %b",
                       m_tdata, m_tuser, m_tlast);
                n_fail++;
            end else begin
                head = decoded_q.pop_front();
                if (m_tdata[7:0] !== head.data) begin
                    $error("out_byte: expected %h, got %h", head.data, m_tdata[7:0]);
                    n_fail++;
                end
                if (m_tdata[9:8] !== head.st) begin
                    $error("status: expected %0d, got %0d", head.st, m_tdata[9:8]);
                    n_fail++;
                end
                if (m_tdata[15:10] !== 6'd0) begin
                    $error("tdata padding: expected 0, got %h", m_tdata[15:10]);
                    n_fail++;
                end
                if (m_tuser !== head.has) begin
                    $error("has_byte: expected %b, got %b", head.has, m_tuser);
                    n_fail++;
                end
                if (m_tlast !== head.last) begin
                    $error("last_of_run: expected %b, got %b", head.last, m_tlast);
                    n_fail++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= stall_pct[idle_mode]);
    end

    initial begin
        int         pick;
        logic [7:0] h0;
        restart_decoder();

        demo_tbl = '{
            '{8'h10, 1'b0, 1'b1, '{8'h00, 1'b0, lzsd_pkg::ST_RUNNING,  1'b1}},
            '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, lzsd_pkg::ST_RUNNING,  1'b1}},
            '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, lzsd_pkg::ST_RUNNING,  1'b1}},
            '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, lzsd_pkg::ST_FINISHED, 1'b1}},
            '{8'hFF, 1'b0, 1'b1, '{8'h00, 1'b0, lzsd_pkg::ST_FINISHED, 1'b1}},
            '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, lzsd_pkg::ST_BAD_TYPE, 1'b1}},
            '{8'h55, 1'b0, 1'b1, '{8'h00, 1'b0, lzsd_pkg::ST_BAD_TYPE, 1'b1}},
            '{8'h9F, 1'b1, 1'b1, '{8'h00, 1'b0, lzsd_pkg::ST_RUNNING,  1'b1}},
            '{8'h30, 1'b0, 1'b1, '{8'h00, 1'b0, lzsd_pkg::ST_RUNNING,  1'b1}},
            '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, lzsd_pkg::ST_RUNNING,  1'b1}},
            '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, lzsd_pkg::ST_RUNNING,  1'b1}},
            '{8'h1F, 1'b0, 1'b1, '{8'h00, 1'b0, lzsd_pkg::ST_RUNNING,  1'b1}},
            '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, lzsd_pkg::ST_RUNNING,  1'b1}},
            '{8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b1, lzsd_pkg::ST_RUNNING,  1'b1}},
            '{8'hA5, 1'b0, 1'b1, '{8'hA5, 1'b1, lzsd_pkg::ST_RUNNING,  1'b1}},
            '{8'hF0, 1'b0, 1'b1, '{8'h00, 1'b0, lzsd_pkg::ST_RUNNING,  1'b1}},
            '{8'h00, 1'b0, 1'b0, '{8'h00, 1'b0, lzsd_pkg::ST_RUNNING,  1'b0}},
            '{8'h10, 1'b1, 1'b1, '{8'h00, 1'b0, lzsd_pkg::ST_RUNNING,  1'b1}},
            '{8'hFF, 1'b0, 1'b1, '{8'h00, 1'b0, lzsd_pkg::ST_RUNNING,  1'b1}},
            '{8'hFF, 1'b0, 1'b1, '{8'h00, 1'b0, lzsd_pkg::ST_RUNNING,  1'b1}},
            '{8'hFF, 1'b0, 1'b1, '{8'h00, 1'b0, lzsd_pkg::ST_RUNNING,  1'b1}},
            '{8'hFF, 1'b0, 1'b1, '{8'h00, 1'b0, lzsd_pkg::ST_RUNNING,  1'b1}},
            '{8'h0F, 1'b0, 1'b1, '{8'h00, 1'b0, lzsd_pkg::ST_RUNNING,  1'b1}},
            '{8'hFF, 1'b0, 1'b1, '{8'h00, 1'b0, lzsd_pkg::ST_BAD_DIST, 1'b1}}
        };
        foreach (demo_tbl[r])
            stim_q.push_back(demo_tbl[r]);

        while (stim_q.size() - N_DEMO < RAND_REQS) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                repeat ($urandom_range(4, 1))
                    add_req(8'($urandom), $urandom_range(3) == 0);
            end else if (pick < 14) begin
                h0 = 8'($urandom);
                while (h0[6:4] == lzsd_pkg::TYPE_LZ77)
                    h0 = 8'($urandom);
                add_req(h0, 1'b1);
            end else if (pick < 20) begin
                emit_stream(24'd0, 0, 1'b0, 1000);
            end else if (pick < 30) begin
                emit_stream({8'($urandom), 8'($urandom), 8'($urandom)} | 24'h000100, 10, 1'b0,
                            $urandom_range(30, 6));
            end else begin
                emit_stream(24'($urandom_range(60, 1)), 8, 1'b0, 1000);
            end
        end
        // One stream made mostly of longest matches, so that full-length copies run
        // back to back.
        emit_stream(24'($urandom_range(400, 300)), 0, 1'b1, 80);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < stim_q.size(); i++) begin
            idle_mode = (i < N_DEMO) ? 0 : ((i - N_DEMO) / MODE_SPAN) % 4;
            while ($urandom_range(99) < gap_pct[idle_mode]) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= stim_q[i].data;
            s_tuser  <= stim_q[i].restart;
            do @(posedge aclk); while (!s_tready);
            decode_byte(stim_q[i].data, stim_q[i].restart);
            if (stim_q[i].typed)
                decoded_q.push_back(stim_q[i].want);
            else
                foreach (step_out[k])
                    decoded_q.push_back(step_out[k]);
        end
        s_tvalid <= 1'b0;

        while (decoded_q.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("run covered %0d requests (%0d directed) over %0d generated streams",
                 stim_q.size(), N_DEMO, n_streams);
        $display("%0d results checked under all idle and stall mixes, longest copies included",
                 n_results);
        if (n_fail == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
